>>> src/spma_pkg.sv
package spma_pkg;
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_STORE = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] address;
    logic [1:0]  access_size;
    logic [63:0] write_data;
  } spma_req_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic        misaligned;
    logic        not_defined;
    logic        new_region;
    logic        table_full;
  } spma_rsp_t;
endpackage

>>> src/spma_if.sv
interface spma_req_if;
  import spma_pkg::*;
  logic      valid;
  logic      ready;
  spma_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface spma_rsp_if;
  import spma_pkg::*;
  logic      valid;
  logic      ready;
  spma_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/spma_ram.sv
module spma_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> src/spma_front.sv
module spma_front #(
  parameter int PAGE_BITS = 12,
  parameter int NUM_PAGES = 16,
  parameter int ADDR_BITS = 32,
  parameter int SLOT_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            enable,
  input  logic            in_valid,
  output logic            in_ready,
  input  spma_pkg::spma_req_t in_data,
  // classified word toward the back end
  output logic            q_valid,
  input  logic            q_ready,
  output spma_pkg::spma_req_t q_req,
  output logic            q_hit,
  output logic            q_mis,
  output logic            q_nr,
  output logic            q_full,
  output logic [SLOT_W-1:0] q_slot
);
  import spma_pkg::*;
  localparam int TAG_W = ((ADDR_BITS < 32) ? ADDR_BITS : 32) - PAGE_BITS;
  localparam int CNT_W = $clog2(NUM_PAGES + 1);

  logic [TAG_W-1:0] page_tag [NUM_PAGES];
  logic [NUM_PAGES-1:0] page_valid;
  logic [CNT_W-1:0] pages_used;

  logic [31:0] addr;
  logic [TAG_W-1:0] tag;
  logic hit, mis, store;
  logic [SLOT_W-1:0] hit_slot;
  logic [7:0] nb_mask;
  logic accept, alloc, no_room;

  // Address masked to the machine's address width.
  always_comb begin
    addr = in_data.address;
    if (ADDR_BITS < 32) addr = in_data.address & ((32'h1 << (ADDR_BITS % 32)) - 32'h1);
    tag = addr[PAGE_BITS +: TAG_W];
    nb_mask = (8'h1 << in_data.access_size) - 8'h1;
    mis = (addr[2:0] & nb_mask[2:0]) != 3'b0;
    store = in_data.req_type == REQ_STORE;
  end

  // Associative lookup over the page table.
  always_comb begin
    hit = 1'b0;
    hit_slot = '0;
    for (int i = 0; i < NUM_PAGES; i++) begin
      if (!hit && page_valid[i] && page_tag[i] == tag) begin
        hit = 1'b1;
        hit_slot = SLOT_W'(i);
      end
    end
  end

  // An aligned store to an unmapped page takes the next free slot if there is one.
  assign accept = in_valid && in_ready;
  assign alloc = store && !mis && !hit && pages_used < CNT_W'(NUM_PAGES);
  assign no_room = store && !mis && !hit && !(pages_used < CNT_W'(NUM_PAGES));

  // One-entry queue register toward the back end.
  assign in_ready = enable && (!q_valid || q_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
      page_valid <= '0;
      pages_used <= '0;
    end else begin
      q_valid <= accept || (q_valid && !q_ready);
      if (accept && alloc) begin
        page_valid[pages_used[SLOT_W-1:0]] <= 1'b1;
        pages_used <= pages_used + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_req <= '{req_type: in_data.req_type, address: addr,
                 access_size: in_data.access_size, write_data: in_data.write_data};
      q_mis <= mis;
      q_hit <= hit || alloc;
      q_nr <= alloc;
      q_full <= no_room;
      q_slot <= alloc ? pages_used[SLOT_W-1:0] : hit_slot;
      if (alloc) page_tag[pages_used[SLOT_W-1:0]] <= tag;
    end
  end
endmodule

>>> src/spma_back.sv
module spma_back #(
  parameter int PAGE_BITS = 12,
  parameter int NUM_PAGES = 16,
  parameter int SLOT_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1
) (
  input  logic            clk,
  input  logic            rst,
  output logic            clear_done,
  input  logic            q_valid,
  output logic            q_ready,
  input  spma_pkg::spma_req_t q_req,
  input  logic            q_hit,
  input  logic            q_mis,
  input  logic            q_nr,
  input  logic            q_full,
  input  logic [SLOT_W-1:0] q_slot,
  spma_rsp_if.source      rsp
);
  import spma_pkg::*;
  localparam int WOFF_W = PAGE_BITS - 3;
  localparam int DEPTH = NUM_PAGES << WOFF_W;
  localparam int WA_W = $clog2(DEPTH);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD0   = 3'd2;
  localparam logic [2:0] S_RD1   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state;
  logic [WA_W-1:0] clr_addr;
  logic [WA_W-1:0] word_addr;
  logic last_word;
  logic [63:0] lo_word;
  logic [127:0] pair;
  logic [63:0] shifted, size_mask, rd_val, mrg;
  logic [63:0] ram_rdata, ram_wdata;
  logic [WA_W-1:0] ram_raddr, ram_waddr;
  logic ram_we;
  logic [2:0] boff;
  spma_rsp_t rsp_r;

  assign boff = q_req.address[2:0];
  assign word_addr = WA_W'({q_slot, q_req.address[PAGE_BITS-1:3]});
  assign last_word = &q_req.address[PAGE_BITS-1:3];
  assign size_mask = (q_req.access_size == 2'd3) ? '1 :
                     ((64'h1 << (8 * (32'h1 << q_req.access_size))) - 64'h1);
  assign clear_done = state != S_CLEAR;

  // The lower word is on the read port in S_RD0; the upper word is then
  // addressed and stays on the port through S_FIN.
  always_comb begin
    ram_raddr = word_addr;
    if ((state == S_RD0 || state == S_RD1) && !last_word) ram_raddr = word_addr + WA_W'(1);
  end

  // Aligned accesses stay in one word; merge store bytes into it.
  assign mrg = (lo_word & ~(size_mask << (8 * boff))) |
               ((q_req.write_data & size_mask) << (8 * boff));
  assign pair = {(last_word ? 64'h0 : ram_rdata), lo_word};
  assign shifted = 64'(pair >> (8 * boff));
  assign rd_val = shifted & size_mask;

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = word_addr;
    ram_wdata = mrg;
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == S_FIN && q_req.req_type == REQ_STORE && q_hit && !q_mis) begin
      ram_we = 1'b1;
    end
  end

  spma_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign q_ready = state == S_FIN;
  assign rsp.valid = state == S_OUT;
  assign rsp.data = rsp_r;

  // Sequencer: clear sweep, then read, read, finish, output per word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + WA_W'(1);
          if (clr_addr == WA_W'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: if (q_valid) state <= S_RD0;
        S_RD0: state <= S_RD1;
        S_RD1: state <= S_FIN;
        S_FIN: state <= S_OUT;
        S_OUT: if (rsp.ready) state <= q_valid ? S_RD0 : S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RD0) lo_word <= ram_rdata;
    if (state == S_FIN) begin
      rsp_r.misaligned <= q_mis;
      rsp_r.not_defined <= q_req.req_type == REQ_LOAD && !q_hit;
      rsp_r.new_region <= q_nr;
      rsp_r.table_full <= q_full;
      rsp_r.read_data <= (q_req.req_type == REQ_LOAD && q_hit) ? rd_val : 64'h0;
    end
  end
endmodule

>>> src/sparse_paged_memory_access_unit.sv
// Channel   Dir  Payload
// req       in   req_type, address, access_size, write_data
// rsp       out  read_data, misaligned, not_defined, new_region, table_full
//
// In the back end each word passes two reads of the single RAM read port (the word
// and the next for page-local spans), a finish state with the store write, and the
// output state; from idle the back end first leaves the idle state.
// The front classifies and allocates pages and holds one word ahead.
// After reset a clearing pass zeroes all NUM_PAGES*2^PAGE_BITS/8 words of storage;
// no request is taken until it ends. The response is held while rsp.ready is low.
module sparse_paged_memory_access_unit #(
  parameter int PAGE_BITS = 12,
  parameter int NUM_PAGES = 16,
  parameter int ADDR_BITS = 32
) (
  input logic      clk,
  input logic      rst,
  spma_req_if.sink req,
  spma_rsp_if.source rsp
);
  import spma_pkg::*;
  localparam int SLOT_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;

  logic q_valid, q_ready, q_hit, q_mis, q_nr, q_full, clear_done;
  spma_req_t q_req;
  logic [SLOT_W-1:0] q_slot;

  spma_front #(.PAGE_BITS(PAGE_BITS), .NUM_PAGES(NUM_PAGES), .ADDR_BITS(ADDR_BITS)) u_front (
    .clk(clk), .rst(rst), .enable(clear_done),
    .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req), .q_hit(q_hit),
    .q_mis(q_mis), .q_nr(q_nr), .q_full(q_full), .q_slot(q_slot)
  );

  spma_back #(.PAGE_BITS(PAGE_BITS), .NUM_PAGES(NUM_PAGES)) u_back (
    .clk(clk), .rst(rst), .clear_done(clear_done),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req), .q_hit(q_hit),
    .q_mis(q_mis), .q_nr(q_nr), .q_full(q_full), .q_slot(q_slot), .rsp(rsp)
  );
endmodule

>>> tb/tb_sparse_paged_memory_access_unit.sv
module tb_sparse_paged_memory_access_unit;
  import spma_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGE_BITS = 12;
  localparam int NUM_PAGES = 16;
  localparam int PAGE_BYTES = 1 << PAGE_BITS;
  localparam int LIMIT_CYCLES = 1500000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  spma_req_if req_ch ();
  spma_rsp_if rsp_ch ();

  sparse_paged_memory_access_unit #(
    .PAGE_BITS(PAGE_BITS),
    .NUM_PAGES(NUM_PAGES),
    .ADDR_BITS(32)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source)
  );

  always #6 clk = ~clk;

  // Shadow copy of the page table and storage.
  logic [19:0] shadow_tag [NUM_PAGES];
  int unsigned shadow_used;
  logic [7:0] shadow_bytes [int unsigned];

  spma_req_t pending_words [$];
  spma_rsp_t expected_rsp [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit hold_sender = 1'b0;
  bit stim_done = 1'b0;

  // Predicts the response of one access and updates the shadow memory.
  function automatic spma_rsp_t predict_access(spma_req_t r);
    spma_rsp_t o;
    int slot;
    int unsigned nbytes;
    int unsigned offset;
    logic [19:0] pg;
    o = '0;
    slot = -1;
    nbytes = 1 << r.access_size;
    pg = r.address[31:PAGE_BITS];
    offset = r.address[PAGE_BITS-1:0];
    o.misaligned = (r.address & (nbytes - 1)) != 0;
    for (int i = 0; i < int'(shadow_used); i++)
      if (shadow_tag[i] == pg) slot = i;
    if (r.req_type == REQ_LOAD) begin
      if (slot < 0) begin
        o.not_defined = 1'b1;
      end else begin
        for (int k = 0; k < int'(nbytes); k++)
          if (offset + k < PAGE_BYTES && shadow_bytes.exists(slot * PAGE_BYTES + offset + k))
            o.read_data[8*k +: 8] = shadow_bytes[slot * PAGE_BYTES + offset + k];
      end
    end else if (!o.misaligned) begin
      if (slot < 0) begin
        if (shadow_used >= NUM_PAGES) begin
          o.table_full = 1'b1;
        end else begin
          slot = shadow_used;
          shadow_tag[slot] = pg;
          shadow_used++;
          o.new_region = 1'b1;
        end
      end
      if (slot >= 0)
        for (int k = 0; k < int'(nbytes); k++)
          if (offset + k < PAGE_BYTES)
            shadow_bytes[slot * PAGE_BYTES + offset + k] = r.write_data[8*k +: 8];
    end
    return o;
  endfunction

  function automatic spma_req_t make_access(logic op, logic [31:0] a, logic [1:0] sz,
                                            logic [63:0] d);
    spma_req_t r;
    r.req_type = op;
    r.address = a;
    r.access_size = sz;
    r.write_data = d;
    return r;
  endfunction

  // Page numbers used by the random part; a few beyond the table size.
  logic [19:0] page_pool [24];

  function automatic spma_req_t random_access();
    logic [31:0] a;
    logic [1:0] sz;
    sz = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 9) == 0) begin
      a = $urandom();
    end else begin
      a[31:PAGE_BITS] = page_pool[$urandom_range(0, shadow_used < NUM_PAGES ? 17 : 23)];
      if ($urandom_range(0, 7) == 0)
        a[PAGE_BITS-1:0] = PAGE_BITS'(PAGE_BYTES - $urandom_range(1, 8));
      else
        a[PAGE_BITS-1:0] =
            PAGE_BITS'($urandom_range(0, 63) << ($urandom_range(0, 3) == 0 ? 0 : sz));
    end
    return make_access($urandom_range(0, 99) < 45, a, sz, {$urandom(), $urandom()});
  endfunction

  // Stimulus: directed accesses, then random ones with one drain pause.
  initial begin
    logic [63:0] ones;
    ones = '1;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    for (int i = 0; i < 24; i++) page_pool[i] = 20'($urandom());
    page_pool[0] = 20'h00000;
    page_pool[1] = 20'hFFFFF;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Unmapped loads, extremes, aligned and misaligned stores, page end.
    pending_words.push_back(make_access(REQ_LOAD, 32'h0000_0000, 2'd3, '0));
    pending_words.push_back(make_access(REQ_LOAD, 32'hFFFF_FFFF, 2'd0, ones));
    pending_words.push_back(make_access(REQ_STORE, 32'h0000_0003, 2'd2, ones));
    pending_words.push_back(make_access(REQ_STORE, 32'h0000_0000, 2'd3, ones));
    pending_words.push_back(make_access(REQ_LOAD, 32'h0000_0000, 2'd3, '0));
    pending_words.push_back(make_access(REQ_LOAD, 32'h0000_0003, 2'd3, '0));
    pending_words.push_back(make_access(REQ_STORE, 32'h0000_0008, 2'd0, 64'hA5));
    pending_words.push_back(make_access(REQ_STORE, 32'h0000_000A, 2'd1, 64'h1234));
    pending_words.push_back(make_access(REQ_STORE, 32'h0000_000C, 2'd2, 64'hDEADBEEF));
    pending_words.push_back(make_access(REQ_LOAD, 32'h0000_0008, 2'd3, '0));
    pending_words.push_back(make_access(REQ_STORE, 32'hFFFF_FFF8, 2'd3, ones));
    pending_words.push_back(make_access(REQ_LOAD, 32'hFFFF_FFFC, 2'd3, '0));
    pending_words.push_back(make_access(REQ_LOAD, 32'hFFFF_FFFF, 2'd1, '0));
    pending_words.push_back(make_access(REQ_LOAD, 32'hFFFF_F000, 2'd2, '0));
    pending_words.push_back(make_access(REQ_STORE, 32'h0000_0FFF, 2'd1, ones));
    pending_words.push_back(make_access(REQ_LOAD, 32'h0000_0FFD, 2'd2, '0));
    wait (pending_words.size() == 0);

    // Fill the table, then hit it full.
    for (int n = 0; n < 1800; n++) begin
      if (n == 900) begin
        hold_sender = 1'b1;
        @(posedge clk);
        wait (!req_ch.valid);
        wait (expected_rsp.size() == 0);
        hold_sender = 1'b0;
      end
      pending_words.push_back(random_access());
      wait (pending_words.size() < 4);
    end
    wait (pending_words.size() == 0);
    stim_done = 1'b1;
  end

  // Sender: random gap before each word.
  int unsigned send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && req_ch.ready) begin
      expected_rsp.push_back(predict_access(req_ch.data));
      req_ch.valid <= 1'b0;
      send_gap <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 9);
    end else if (!req_ch.valid && send_gap > 0) begin
      send_gap <= send_gap - 1;
    end else if (!req_ch.valid && !hold_sender && pending_words.size() > 0) begin
      req_ch.data <= pending_words.pop_front();
      req_ch.valid <= 1'b1;
    end
  end

  // Receiver: random stalls, compares each response with the oldest prediction.
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected response %h", rsp_ch.data);
        end else begin
          spma_rsp_t e;
          e = expected_rsp.pop_front();
          if (e.read_data !== rsp_ch.data.read_data || e.misaligned !== rsp_ch.data.misaligned
              || e.not_defined !== rsp_ch.data.not_defined
              || e.new_region !== rsp_ch.data.new_region
              || e.table_full !== rsp_ch.data.table_full) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected %h %b%b%b%b, got %h %b%b%b%b",
                       e.read_data, e.misaligned, e.not_defined, e.new_region, e.table_full,
                       rsp_ch.data.read_data, rsp_ch.data.misaligned, rsp_ch.data.not_defined,
                       rsp_ch.data.new_region, rsp_ch.data.table_full);
          end
        end
        stall_left <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 9);
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // End of run: drain, settle, then report.
  initial begin
    wait (stim_done && expected_rsp.size() == 0);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_rsp.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Timeout guard.
  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("Some tests failed");
    $finish;
  end
endmodule
